// ===== design/npp_pkg.sv =====
package npp_pkg;

   localparam int CAPACITY = 64;
   localparam int COORD_W  = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int POINT_W  = 2 * COORD_W;
   localparam int SQ_W     = 2 * COORD_W + 1;
   localparam int DIST_W   = SQ_W + 1;
   localparam int REQ_DATA_W = POINT_W;
   localparam int RSP_DATA_W = ((2 * COORD_W + CNT_W + 7) / 8) * 8;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [1:0] {
      RSP_OK    = 2'd0,
      RSP_EMPTY = 2'd1,
      RSP_FULL  = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SCAN_WAIT,
      S_SHIFT,
      S_SHIFT_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic           capture;
      logic           push_wr;
      logic           scan_init;
      logic           scan_rd;
      logic           shift_init;
      logic           shift_rd;
      logic           cnt_dec;
      logic           emit;
      logic           emit_best;
      rsp_status_type emit_status;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic empty;
      logic full;
      logic idx_last;
      logic shift_end;
      logic pipe_busy;
      logic out_free;
   } stat_type;

endpackage

// ===== design/npp_ctrl.sv =====
module npp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  npp_pkg::stat_type st,
   output npp_pkg::cmd_type  cmd
);
   import npp_pkg::*;

   state_type      state_ff, state_in;
   rsp_status_type res_ff, res_in;
   logic           best_ff, best_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= RSP_OK;
         best_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
         best_ff  <= best_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      res_in     = res_ff;
      best_in    = best_ff;
      cmd        = '0;
      cmd.emit_status = res_ff;
      cmd.emit_best   = best_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            best_in = 1'b0;
            if (!st.is_pop) begin
               if (st.full) begin
                  res_in = RSP_FULL;
               end else begin
                  res_in      = RSP_OK;
                  cmd.push_wr = 1'b1;
               end
               state_in = S_DONE;
            end else if (st.empty) begin
               res_in   = RSP_EMPTY;
               state_in = S_DONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (st.idx_last) begin
               state_in = S_SCAN_WAIT;
            end
         end
         S_SCAN_WAIT: begin
            if (!st.pipe_busy) begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (st.shift_end) begin
               state_in = S_SHIFT_WAIT;
            end else begin
               cmd.shift_rd = 1'b1;
            end
         end
         S_SHIFT_WAIT: begin
            if (!st.pipe_busy) begin
               cmd.cnt_dec = 1'b1;
               res_in      = RSP_OK;
               best_in     = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/npp_datapath.sv =====
module npp_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  npp_pkg::cmd_type                        cmd,
   output npp_pkg::stat_type                       st,
   input  logic                                    req_mode,
   input  logic signed [npp_pkg::COORD_W-1:0]      req_x,
   input  logic signed [npp_pkg::COORD_W-1:0]      req_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [npp_pkg::COORD_W-1:0]      rsp_found_x,
   output logic signed [npp_pkg::COORD_W-1:0]      rsp_found_y,
   output npp_pkg::rsp_status_type                 rsp_status,
   output logic [npp_pkg::CNT_W-1:0]               rsp_remaining
);
   import npp_pkg::*;

   logic [POINT_W-1:0] point_mem_ff [CAPACITY];

   logic                      mode_ff;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic [CNT_W-1:0]          count_ff, idx_ff, idx_plus;
   logic [IDX_W-1:0]          rd_addr, wr_addr;
   logic [POINT_W-1:0]        rd_data_ff, wr_data;
   logic                      wr_en;

   logic                      s1_v_ff, s2_v_ff, sh_v_ff, best_v_ff;
   logic [IDX_W-1:0]          s1_idx_ff, s2_idx_ff, sh_addr_ff, best_idx_ff;
   logic [POINT_W-1:0]        s2_pt_ff, best_pt_ff;
   logic [SQ_W-1:0]           sq_x_ff, sq_y_ff;
   logic [DIST_W-1:0]         best_dist_ff, cand_dist;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [2*COORD_W+1:0] prod_x, prod_y;
   logic                      take_best;

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   rsp_status_type            rsp_status_ff;
   logic [CNT_W-1:0]          rsp_rem_ff;

   assign idx_plus = idx_ff + CNT_W'(1);

   // During the shift pass entry idx+1 is read and written to idx in the next cycle.
   assign rd_addr = cmd.shift_rd ? idx_plus[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_en   = cmd.push_wr | sh_v_ff;
   assign wr_addr = cmd.push_wr ? count_ff[IDX_W-1:0] : sh_addr_ff;
   assign wr_data = cmd.push_wr ? {qy_ff, qx_ff} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= point_mem_ff[rd_addr];
   end

   assign dx = $signed({rd_data_ff[COORD_W-1], rd_data_ff[COORD_W-1:0]})
             - $signed({qx_ff[COORD_W-1], qx_ff});
   assign dy = $signed({rd_data_ff[POINT_W-1], rd_data_ff[POINT_W-1:COORD_W]})
             - $signed({qy_ff[COORD_W-1], qy_ff});
   assign prod_x = dx * dx;
   assign prod_y = dy * dy;

   assign cand_dist = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   // Strict compare keeps the earliest entry when distances tie.
   assign take_best = s2_v_ff && (!best_v_ff || cand_dist < best_dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         sh_v_ff      <= 1'b0;
         best_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.scan_rd;
         s2_v_ff <= s1_v_ff;
         sh_v_ff <= cmd.shift_rd;
         if (cmd.push_wr) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.scan_init) begin
            best_v_ff <= 1'b0;
         end else if (take_best) begin
            best_v_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         qx_ff   <= req_x;
         qy_ff   <= req_y;
      end
      if (cmd.scan_init) begin
         idx_ff <= '0;
      end else if (cmd.shift_init) begin
         idx_ff <= {1'b0, best_idx_ff};
      end else if (cmd.scan_rd || cmd.shift_rd) begin
         idx_ff <= idx_plus;
      end
      s1_idx_ff  <= idx_ff[IDX_W-1:0];
      sh_addr_ff <= idx_ff[IDX_W-1:0];
      s2_idx_ff  <= s1_idx_ff;
      s2_pt_ff   <= rd_data_ff;
      sq_x_ff    <= prod_x[SQ_W-1:0];
      sq_y_ff    <= prod_y[SQ_W-1:0];
      if (take_best) begin
         best_dist_ff <= cand_dist;
         best_idx_ff  <= s2_idx_ff;
         best_pt_ff   <= s2_pt_ff;
      end
      if (cmd.emit) begin
         rsp_x_ff      <= cmd.emit_best ? best_pt_ff[COORD_W-1:0] : '1;
         rsp_y_ff      <= cmd.emit_best ? best_pt_ff[POINT_W-1:COORD_W] : '1;
         rsp_status_ff <= cmd.emit_status;
         rsp_rem_ff    <= count_ff;
      end
   end

   assign st.is_pop    = (mode_ff == MODE_POP);
   assign st.empty     = (count_ff == '0);
   assign st.full      = (count_ff == CNT_W'(CAPACITY));
   assign st.idx_last  = (idx_ff == count_ff - CNT_W'(1));
   assign st.shift_end = (idx_plus == count_ff);
   assign st.pipe_busy = s1_v_ff | s2_v_ff | sh_v_ff;
   assign st.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found_x   = rsp_x_ff;
   assign rsp_found_y   = rsp_y_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_remaining = rsp_rem_ff;

endmodule

// ===== design/nearest_point_pool.sv =====
// Nearest point pool: holds up to CAPACITY (64) signed Q12.4 points in order.
// Request beats: req_tuser is the mode (push or pop), req_tdata carries x and y.
// A push appends the point, or is dropped with a full status when the pool is full.
// A pop removes and returns the stored point closest to (x,y) in squared
// Euclidean distance; ties go to the oldest entry, later entries keep their order.
// Every request produces exactly one response beat with found_x, found_y,
// the status code on rsp_tuser and the number of points left.
// A push or an empty pop answers after the dispatch step, with no scan. A pop
// on N points scans every entry through the distance pipeline and then
// closes the gap behind the removed entry k; both passes go through the
// single port pair of the point memory.
// One request is in work at a time; the next is taken once the current result
// sits in the output register, even if the receiver has not taken it yet.
// While rsp_tready is low the response holds and the next result waits.
// Reset (synchronous) empties the pool and drops any pending response.
module nearest_point_pool (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [npp_pkg::REQ_DATA_W-1:0]     req_tdata,  // x[15:0], y[31:16]
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [npp_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // found_x[15:0], found_y[31:16],
                                                          // remaining[38:32], zero[39]
   output logic [1:0]                         rsp_tuser   // status
);
   import npp_pkg::*;

   cmd_type                   cmd;
   stat_type                  st;
   logic signed [COORD_W-1:0] found_x, found_y;
   rsp_status_type            status;
   logic [CNT_W-1:0]          remaining;

   npp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   npp_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_mode      (req_tuser),
      .req_x         (req_tdata[COORD_W-1:0]),
      .req_y         (req_tdata[POINT_W-1:COORD_W]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_found_x   (found_x),
      .rsp_found_y   (found_y),
      .rsp_status    (status),
      .rsp_remaining (remaining)
   );

   assign rsp_tdata = {{(RSP_DATA_W - POINT_W - CNT_W){1'b0}}, remaining, found_y, found_x};
   assign rsp_tuser = status;

endmodule

// ===== design/npp_checker.sv =====
module npp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [npp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser
);
   import npp_pkg::*;

   // A held response beat must not change under backpressure.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Only one request is in work, so the port closes right after a beat is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RSP_EMPTY |->
         rsp_tdata[POINT_W+CNT_W-1:POINT_W] == '0 && rsp_tdata[POINT_W-1:0] == '1)
      else $error("empty pop response malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RSP_FULL |->
         rsp_tdata[POINT_W+CNT_W-1:POINT_W] == CNT_W'(CAPACITY)
         && rsp_tdata[POINT_W-1:0] == '1)
      else $error("full push response malformed");

endmodule

bind nearest_point_pool npp_checker u_npp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
